[rtl/efs_pkg.sv]
// shared types and constants of the earliest-free server scheduler
// item structs, heap entry and memory request structs, heap ordering function
// no dependencies
package efs_pkg;

    localparam int TIME_W    = 48;
    localparam int SRV_W     = 4;
    localparam int OPER_W    = 16;
    localparam int CNT_W     = 5;
    localparam int POS_W     = 5;
    localparam int PROD_W    = 2 * OPER_W;
    localparam int CNT_MAX   = 31;
    localparam int RATE_SLOTS = 16;
    localparam int CNT_RESET = 16;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    localparam logic OP_RATE = 1'b0;
    localparam logic OP_JOB  = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [SRV_W-1:0]  server_index;
        logic [OPER_W-1:0] operand_value;
    } in_item_t;

    typedef struct packed {
        logic [SRV_W-1:0]  assigned_server;
        logic [TIME_W-1:0] finish_time;
        logic [TIME_W-1:0] makespan;
    } out_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] time_val;
        logic [POS_W-1:0]  idx;
    } heap_entry_t;

    typedef struct packed {
        logic             l_en;
        logic [POS_W-1:0] l_addr;
        logic             r_en;
        logic [POS_W-1:0] r_addr;
    } heap_rd_req_t;

    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] addr;
        heap_entry_t      data;
    } heap_wr_t;

    function automatic logic earlier(input heap_entry_t a, input heap_entry_t b);
        return (a.time_val < b.time_val) ||
               ((a.time_val == b.time_val) && (a.idx < b.idx));
    endfunction

endpackage

[rtl/earliest_free_server_scheduler_core.sv]
// earliest-free server scheduler, top level
// control sequencer, rate table and makespan around the heap memory
// depends on efs_pkg and efs_heap_mem
//
// usage: s_item carries either a rate load (opcode 0) or a job (opcode 1). each
// accepted item gives exactly one m_item. a job goes to the server at the heap
// root (earliest free, lowest index on ties), whose free time grows by its rate
// times the job's unit count, saturating; m_item gives that server, its new free
// time and the running makespan. a rate load echoes the index with time 0.
// cfg_data writes the server count (0 taken as 1, clamped to the heap depth);
// the write clears all free times and the makespan, rates are kept.
// a rate load goes from acceptance straight to the output load; a job passes
// through the root read, the multiply, the add, the sift-down (one heap level
// per step, until the entry stops moving) and then the output load.
// one item is in work at a time; s_ready is high only while the sequencer is
// idle, also while an earlier result still waits in the output register. when
// m_ready is low a finished result holds in the sequencer until the output
// register frees. reset clears rates, free times, makespan and sets the server
// count to 16 (or the heap depth if smaller); no clearing pass is needed.
module earliest_free_server_scheduler_core #(
    parameter int MAX_SERVERS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  efs_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output efs_pkg::out_item_t  m_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [4:0]          cfg_data
);
    import efs_pkg::*;

    localparam int HEAP_DEPTH = (MAX_SERVERS < CNT_MAX) ? MAX_SERVERS : CNT_MAX;
    localparam int RATE_DEPTH = (MAX_SERVERS < RATE_SLOTS) ? MAX_SERVERS : RATE_SLOTS;
    localparam int RATE_AW    = $clog2(RATE_DEPTH);
    localparam logic [CNT_W-1:0] COUNT_INIT =
        CNT_W'((CNT_RESET < HEAP_DEPTH) ? CNT_RESET : HEAP_DEPTH);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ROOT = 3'd1;
    localparam logic [2:0] ST_ADD  = 3'd2;
    localparam logic [2:0] ST_SIFT = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [TIME_W-1:0]   longest_reg, longest_next;
    logic [OPER_W-1:0]   rate_reg [RATE_DEPTH];
    logic [OPER_W-1:0]   units_reg, units_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    heap_entry_t         cur_reg, cur_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                l_ok_reg, l_ok_next;
    logic                r_ok_reg, r_ok_next;
    out_item_t           res_reg, res_next;
    out_item_t           out_reg, out_next;
    logic                m_valid_reg, m_valid_next;

    logic                in_fire;
    logic                cfg_fire;
    logic                rate_we;
    logic                heap_clear;
    heap_rd_req_t        rd_req;
    heap_wr_t            wr;
    heap_entry_t         rd_l_data;
    heap_entry_t         rd_r_data;
    logic [OPER_W-1:0]   rate_rd;
    logic [TIME_W:0]     sum;
    logic [TIME_W-1:0]   t_new;
    logic [TIME_W-1:0]   span_new;
    logic [POS_W:0]      lpos, rpos;
    heap_entry_t         best_ent;
    logic [POS_W-1:0]    best_pos;
    logic                moved;
    logic [POS_W-1:0]    sift_pos;
    logic [POS_W:0]      lc, rc;
    logic [POS_W:0]      n_ext;
    logic [CNT_W-1:0]    cfg_count;

    efs_heap_mem #(
        .DEPTH (HEAP_DEPTH)
    ) u_heap (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (heap_clear),
        .rd_req    (rd_req),
        .wr        (wr),
        .rd_l_data (rd_l_data),
        .rd_r_data (rd_r_data)
    );

    assign s_ready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign rate_we   = in_fire && (s_item.opcode == OP_RATE) &&
                       ({1'b0, s_item.server_index} < (SRV_W+1)'(RATE_DEPTH));
    assign m_valid   = m_valid_reg;
    assign m_item    = out_reg;

    always_comb begin
        if (cfg_data == '0) begin
            cfg_count = CNT_W'(1);
        end else if (cfg_data > CNT_W'(HEAP_DEPTH)) begin
            cfg_count = CNT_W'(HEAP_DEPTH);
        end else begin
            cfg_count = cfg_data;
        end
    end

    // rate of the server at the root
    assign rate_rd = (rd_l_data.idx < CNT_W'(RATE_DEPTH)) ?
                     rate_reg[rd_l_data.idx[RATE_AW-1:0]] : '0;

    // saturating add of the job's service time
    assign sum      = {1'b0, cur_reg.time_val} + (TIME_W+1)'(prod_reg);
    assign t_new    = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    assign span_new = (t_new > longest_reg) ? t_new : longest_reg;

    // pick the earliest of the moving entry and its children
    assign lpos = {pos_reg, 1'b1};
    assign rpos = {pos_reg, 1'b0} + (POS_W+1)'(2);

    always_comb begin
        best_ent = cur_reg;
        best_pos = pos_reg;
        if (l_ok_reg && earlier(rd_l_data, best_ent)) begin
            best_ent = rd_l_data;
            best_pos = lpos[POS_W-1:0];
        end
        if (r_ok_reg && earlier(rd_r_data, best_ent)) begin
            best_ent = rd_r_data;
            best_pos = rpos[POS_W-1:0];
        end
    end

    assign moved    = (best_pos != pos_reg);
    assign sift_pos = (state_reg == ST_SIFT) ? best_pos : '0;
    assign lc       = {sift_pos, 1'b1};
    assign rc       = {sift_pos, 1'b0} + (POS_W+1)'(2);
    assign n_ext    = {1'b0, count_reg};

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        longest_next = longest_reg;
        units_next   = units_reg;
        prod_next    = prod_reg;
        cur_next     = cur_reg;
        pos_next     = pos_reg;
        l_ok_next    = l_ok_reg;
        r_ok_next    = r_ok_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        heap_clear   = 1'b0;
        rd_req       = '0;
        wr           = '0;

        if (cfg_fire) begin
            count_next   = cfg_count;
            longest_next = '0;
            heap_clear   = 1'b1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_item.opcode == OP_JOB) begin
                        rd_req.l_en   = 1'b1;
                        rd_req.l_addr = '0;
                        units_next    = s_item.operand_value;
                        state_next    = ST_ROOT;
                    end else begin
                        res_next = '{assigned_server: s_item.server_index,
                                     finish_time: '0,
                                     makespan: longest_reg};
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_ROOT: begin
                cur_next   = rd_l_data;
                prod_next  = PROD_W'(rate_rd) * PROD_W'(units_reg);
                state_next = ST_ADD;
            end
            ST_ADD: begin
                cur_next.time_val = t_new;
                longest_next      = span_new;
                res_next = '{assigned_server: cur_reg.idx[SRV_W-1:0],
                             finish_time: t_new,
                             makespan: span_new};
                pos_next      = '0;
                l_ok_next     = lc < n_ext;
                r_ok_next     = rc < n_ext;
                rd_req.l_en   = lc < n_ext;
                rd_req.l_addr = lc[POS_W-1:0];
                rd_req.r_en   = rc < n_ext;
                rd_req.r_addr = rc[POS_W-1:0];
                state_next    = ST_SIFT;
            end
            ST_SIFT: begin
                wr.en   = 1'b1;
                wr.addr = pos_reg;
                if (moved) begin
                    wr.data       = best_ent;
                    pos_next      = best_pos;
                    l_ok_next     = lc < n_ext;
                    r_ok_next     = rc < n_ext;
                    rd_req.l_en   = lc < n_ext;
                    rd_req.l_addr = lc[POS_W-1:0];
                    rd_req.r_en   = rc < n_ext;
                    rd_req.r_addr = rc[POS_W-1:0];
                end else begin
                    wr.data    = cur_reg;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= COUNT_INIT;
            longest_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            longest_reg <= longest_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < RATE_DEPTH; i++) begin
                rate_reg[i] <= '0;
            end
        end else if (rate_we) begin
            rate_reg[s_item.server_index[RATE_AW-1:0]] <= s_item.operand_value;
        end
    end

    always_ff @(posedge aclk) begin
        units_reg <= units_next;
        prod_reg  <= prod_next;
        cur_reg   <= cur_next;
        pos_reg   <= pos_next;
        l_ok_reg  <= l_ok_next;
        r_ok_reg  <= r_ok_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

endmodule

[rtl/efs_heap_mem.sv]
// heap memory: one write port, two registered read ports, per-entry valid bits
// an entry never written since reset or clear reads as time zero with index = position
// depends on efs_pkg
module efs_heap_mem #(
    parameter int DEPTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 clear,
    input  efs_pkg::heap_rd_req_t rd_req,
    input  efs_pkg::heap_wr_t    wr,
    output efs_pkg::heap_entry_t rd_l_data,
    output efs_pkg::heap_entry_t rd_r_data
);
    import efs_pkg::*;

    localparam int AW = $clog2(DEPTH);

    heap_entry_t            heap_mem [DEPTH];
    logic [DEPTH-1:0]       valid_reg;
    heap_entry_t            l_q_reg;
    heap_entry_t            r_q_reg;
    logic                   l_vld_reg;
    logic                   r_vld_reg;
    logic [POS_W-1:0]       l_addr_reg;
    logic [POS_W-1:0]       r_addr_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            heap_mem[wr.addr[AW-1:0]] <= wr.data;
        end
        if (rd_req.l_en) begin
            l_q_reg    <= heap_mem[rd_req.l_addr[AW-1:0]];
            l_vld_reg  <= valid_reg[rd_req.l_addr[AW-1:0]];
            l_addr_reg <= rd_req.l_addr;
        end
        if (rd_req.r_en) begin
            r_q_reg    <= heap_mem[rd_req.r_addr[AW-1:0]];
            r_vld_reg  <= valid_reg[rd_req.r_addr[AW-1:0]];
            r_addr_reg <= rd_req.r_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr.addr[AW-1:0]] <= 1'b1;
        end
    end

    assign rd_l_data = l_vld_reg ? l_q_reg : heap_entry_t'{time_val: '0, idx: l_addr_reg};
    assign rd_r_data = r_vld_reg ? r_q_reg : heap_entry_t'{time_val: '0, idx: r_addr_reg};

endmodule

[sim/earliest_free_server_scheduler_core_test.sv]
// self-checking testbench for earliest_free_server_scheduler_core
// predicts every result with its own copy of the heap, rates and makespan
// depends on efs_pkg and the scheduler rtl
module earliest_free_server_scheduler_core_test;

    import efs_pkg::*;

    localparam int SERVERS = 16;
    localparam int SETTLE_CYCLES = 12;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_item = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_item;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [4:0] cfg_data = '0;

    earliest_free_server_scheduler_core #(
        .MAX_SERVERS(SERVERS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #5 aclk = ~aclk;

    // scheduler state as predicted
    logic [TIME_W-1:0] free_time [SERVERS];
    logic [SRV_W-1:0]  free_srv  [SERVERS];
    logic [OPER_W-1:0] unit_rate [SERVERS];
    logic [TIME_W-1:0] peak_finish;
    int                servers_used;

    in_item_t  job_queue[$];
    out_item_t awaited_results[$];
    out_item_t want;
    int        n_offered = 0;
    int        n_taken = 0;
    int        fails = 0;
    bit        in_took = 1'b0;
    bit        recv_hold = 1'b0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        count_plan[9] = '{0, 31, 3, 16, 1, 17, 7, 2, 12};

    function automatic void clear_free_times();
        for (int i = 0; i < SERVERS; i++) begin
            free_time[i] = '0;
            free_srv[i]  = SRV_W'(i);
        end
        peak_finish = '0;
    endfunction

    function automatic void reset_schedule();
        for (int i = 0; i < SERVERS; i++) unit_rate[i] = '0;
        clear_free_times();
        servers_used = SERVERS;
    endfunction

    function automatic void load_server_count(input logic [4:0] v);
        if (v == 0) servers_used = 1;
        else if (v > SERVERS) servers_used = SERVERS;
        else servers_used = v;
        clear_free_times();
    endfunction

    function automatic bit runs_sooner(input int a, input int b);
        return (free_time[a] < free_time[b]) ||
               ((free_time[a] == free_time[b]) && (free_srv[a] < free_srv[b]));
    endfunction

    function automatic out_item_t dispatch(input in_item_t req);
        out_item_t         res;
        logic [TIME_W:0]   total;
        logic [TIME_W-1:0] t_swap;
        logic [SRV_W-1:0]  s_swap;
        int                p, l, r, best;
        bit                settled;
        res = '0;
        if (req.opcode == OP_RATE) begin
            unit_rate[req.server_index] = req.operand_value;
            res.assigned_server = req.server_index;
            res.finish_time = '0;
            res.makespan = peak_finish;
        end else begin
            total = (TIME_W+1)'(free_time[0]) +
                    (TIME_W+1)'(unit_rate[free_srv[0]]) * (TIME_W+1)'(req.operand_value);
            if (total > (TIME_W+1)'(TIME_MAX)) total = (TIME_W+1)'(TIME_MAX);
            free_time[0] = total[TIME_W-1:0];
            if (free_time[0] > peak_finish) peak_finish = free_time[0];
            res.assigned_server = free_srv[0];
            res.finish_time = free_time[0];
            res.makespan = peak_finish;
            // sift the root down to restore heap order
            p = 0;
            settled = 1'b0;
            while (!settled) begin
                l = 2 * p + 1;
                r = 2 * p + 2;
                best = p;
                if (l < servers_used && runs_sooner(l, best)) best = l;
                if (r < servers_used && runs_sooner(r, best)) best = r;
                if (best == p) begin
                    settled = 1'b1;
                end else begin
                    t_swap = free_time[p];
                    s_swap = free_srv[p];
                    free_time[p] = free_time[best];
                    free_srv[p] = free_srv[best];
                    free_time[best] = t_swap;
                    free_srv[best] = s_swap;
                    p = best;
                end
            end
        end
        return res;
    endfunction

    // item driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_took) begin
            if (job_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_item <= job_queue.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge aclk) begin
        if (!aresetn || recv_hold) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_schedule();
            in_took = 1'b0;
        end else begin
            in_took = s_valid && s_ready;
            if (in_took) begin
                awaited_results.push_back(dispatch(s_item));
                n_taken++;
            end
            if (cfg_valid && cfg_ready) load_server_count(cfg_data);
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result item with none expected: server %0d finish %0d",
                           m_item.assigned_server, m_item.finish_time);
                    fails++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_item.assigned_server !== want.assigned_server) begin
                        $error("assigned_server: expected %0d, got %0d",
                               want.assigned_server, m_item.assigned_server);
                        fails++;
                    end
                    if (m_item.finish_time !== want.finish_time) begin
                        $error("finish_time: expected %0d, got %0d",
                               want.finish_time, m_item.finish_time);
                        fails++;
                    end
                    if (m_item.makespan !== want.makespan) begin
                        $error("makespan: expected %0d, got %0d",
                               want.makespan, m_item.makespan);
                        fails++;
                    end
                end
            end
        end
    end

    function automatic in_item_t make_item(input logic op, input int idx, input int val);
        in_item_t it;
        it.opcode = op;
        it.server_index = SRV_W'(idx);
        it.operand_value = OPER_W'(val);
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        job_queue.push_back(it);
        n_offered++;
    endtask

    function automatic in_item_t random_request();
        in_item_t r;
        r.opcode = ($urandom_range(3) == 0) ? OP_RATE : OP_JOB;
        r.server_index = SRV_W'($urandom_range(15));
        case ($urandom_range(4))
            0: r.operand_value = OPER_W'($urandom_range(15));
            1: r.operand_value = 16'hFFFF - OPER_W'($urandom_range(15));
            2: r.operand_value = '0;
            default: r.operand_value = OPER_W'($urandom);
        endcase
        return r;
    endfunction

    task automatic wait_drained();
        while (n_taken != n_offered || awaited_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_server_count(input logic [4:0] v);
        wait_drained();
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int s_pct, input int r_pct, input int plan_base,
                             input bit long_hold);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int seg = 0; seg < 3; seg++) begin
            write_server_count(5'(count_plan[plan_base + seg]));
            if (long_hold && seg == 1) begin
                fork
                    begin
                        recv_hold <= 1'b1;
                        repeat (300) @(negedge aclk);
                        recv_hold <= 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < 111; k++) begin
                if (seg == 2 && k == 55) wait_drained();
                send_item(random_request());
            end
        end
    endtask

    initial begin
        count_plan[7] = $urandom_range(31);
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: rate zero, extreme rates and counts, every server index bit
        send_item(make_item(OP_JOB, 0, 100));
        send_item(make_item(OP_RATE, 0, 16'hFFFF));
        send_item(make_item(OP_RATE, 15, 1));
        send_item(make_item(OP_RATE, 1, 0));
        send_item(make_item(OP_RATE, 8, 16'h8000));
        send_item(make_item(OP_RATE, 5, 16'h5555));
        send_item(make_item(OP_RATE, 10, 16'hAAAA));
        send_item(make_item(OP_JOB, 3, 16'hFFFF));
        send_item(make_item(OP_JOB, 12, 0));
        send_item(make_item(OP_JOB, 0, 1));
        send_item(make_item(OP_JOB, 0, 16'h8000));
        send_item(make_item(OP_JOB, 0, 16'h5555));
        send_item(make_item(OP_JOB, 0, 16'hAAAA));
        for (int i = 0; i < 10; i++) send_item(make_item(OP_JOB, 0, 16'hFFFF - i));

        // one server at the largest rate, jobs back to back
        write_server_count(5'd1);
        send_item(make_item(OP_RATE, 0, 16'hFFFF));
        for (int i = 0; i < 20; i++) send_item(make_item(OP_JOB, 0, 16'hFFFF));
        send_item(make_item(OP_RATE, 9, 16'h1234));
        send_item(make_item(OP_JOB, 0, 16'hFFFF));

        run_phase(11, 47, 0, 1'b1);
        run_phase(47, 11, 3, 1'b0);
        run_phase(0, 0, 6, 1'b0);

        wait_drained();
        if (fails == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
rtl/efs_pkg.sv
rtl/efs_heap_mem.sv
rtl/earliest_free_server_scheduler_core.sv
sim/earliest_free_server_scheduler_core_test.sv
